// File: rtl/assert_macros.svh
// Assertion macros used by the resize tap/weight RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define RTPW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication, checked outside reset.
`define RTPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define RTPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTPW_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RTPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/rtpw_pkg.sv
// Package: widths, register indexes and defaults for the resize tap/weight generator.
package rtpw_pkg;

  localparam int IDX_W   = 12;
  localparam int SCALE_W = 24;
  localparam int LEN_W   = 13;
  localparam int CHAN_W  = 5;
  localparam int OFS_W   = 16;
  localparam int WGT_W   = 12;
  localparam int PROD_W  = IDX_W + 1 + SCALE_W;   // (2*i+1)*scale, Q17
  localparam int FRAC_W  = 17;                    // Q16 fraction incl. 1.0
  localparam int POSI_W  = PROD_W - 17;           // floor of Q17 position
  localparam int CIDX_W  = 2;

  localparam int COEF_BITS_DEF = 11;

  localparam logic [CIDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LEN   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_CHAN  = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;
  localparam logic [LEN_W-1:0]   LEN_RST   = 13'd2;
  localparam logic [CHAN_W-1:0]  CHAN_RST  = 5'd1;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
  localparam logic [FRAC_W-1:0] HALF_Q16 = 17'd32768;

endpackage

// File: rtl/resize_tap_position_weight_gen_top.sv
// Top level: bilinear resize tap position and weight generator, one axis.
//
// Usage:
//   Input: pulse start with in_dest_index; a request is taken at every edge
//   where start is high and busy is low. busy is tied low: one request can
//   enter every clock, back to back.
//   Output: out_valid strobes for one cycle with out_source_offset,
//   out_weight_left, out_weight_right and out_pick_left. The receiver cannot
//   stall, so there is no backpressure and nothing ever waits.
//   Pipeline: three register stages; throughput is one request per
//   cycle. The stages are the 13x24 scale multiply, the floor/clamp of
//   the Q17 position, and the offset multiply plus rounding.
//   Config: cfg_we writes cfg_wdata into register cfg_index (0 scale,
//   1 source length, 2 channel count); unknown indexes are dropped. Write
//   only while no request is in flight.
//   Reset (sync, active low) clears the pipeline valids and loads scale 1.0,
//   source length 2, one channel. No clearing pass is needed.
`include "assert_macros.svh"
module resize_tap_position_weight_gen_top #(
  parameter int COEF_BITS = rtpw_pkg::COEF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rtpw_pkg::IDX_W-1:0]      in_dest_index,
  output logic                            out_valid,
  output logic [rtpw_pkg::OFS_W-1:0]      out_source_offset,
  output logic [rtpw_pkg::WGT_W-1:0]      out_weight_left,
  output logic [rtpw_pkg::WGT_W-1:0]      out_weight_right,
  output logic                            out_pick_left,
  input  logic                            cfg_we,
  input  logic [rtpw_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [rtpw_pkg::SCALE_W-1:0]    cfg_wdata
);
  import rtpw_pkg::*;

  // max weight the right/left outputs can show
  localparam int WMAX = (COEF_BITS >= 12) ? 4095 : (1 << COEF_BITS);

  // ---------------- configuration registers ----------------
  logic [SCALE_W-1:0] scale_r;
  logic [LEN_W-1:0]   len_r;
  logic [CHAN_W-1:0]  chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      len_r   <= LEN_RST;
      chan_r  <= CHAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: scale_r <= cfg_wdata;
        REG_LEN:   len_r   <= cfg_wdata[LEN_W-1:0];
        REG_CHAN:  chan_r  <= cfg_wdata[CHAN_W-1:0];
        default:   ;
      endcase
    end
  end

  // never holds a request off
  assign busy = 1'b0;

  logic req_acc;
  assign req_acc = start && !busy;

  // ---------------- stage 1: (2*i+1) * scale, Q17 ----------------
  logic              s1_vld_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [PROD_W-1:0] s1_prod_nxt;

  assign s1_prod_nxt = PROD_W'({in_dest_index, 1'b1}) * PROD_W'(scale_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_prod_r <= s1_prod_nxt;
    end
  end

  // ---------------- stage 2: minus 0.5, floor, clamp ----------------
  logic              s2_vld_r;
  logic [LEN_W-1:0]  s2_pos_r;
  logic [FRAC_W-1:0] s2_frac_r;
  logic [LEN_W-1:0]  s2_pos_nxt;
  logic [FRAC_W-1:0] s2_frac_nxt;
  logic [PROD_W-1:0] diff;
  logic              neg;
  logic [POSI_W-1:0] pos_i;
  logic [LEN_W-1:0]  border_m1;

  assign neg       = s1_prod_r < PROD_W'(FRAC_ONE);
  assign diff      = s1_prod_r - PROD_W'(FRAC_ONE);
  assign pos_i     = diff[PROD_W-1:17];
  // short sources behave as two samples
  assign border_m1 = (len_r < LEN_W'(2)) ? LEN_W'(1) : len_r - LEN_W'(1);

  always_comb begin
    s2_pos_nxt  = '0;
    s2_frac_nxt = '0;
    if (!neg) begin
      s2_pos_nxt  = LEN_W'(pos_i);
      s2_frac_nxt = {1'b0, diff[16:1]};
    end
    // right border: pin to the last pair, full weight on the right sample
    if (!neg && (POSI_W'(border_m1) <= pos_i)) begin
      s2_pos_nxt  = border_m1 - LEN_W'(1);
      s2_frac_nxt = FRAC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_pos_r  <= s2_pos_nxt;
      s2_frac_r <= s2_frac_nxt;
    end
  end

  // ---------------- stage 3: offset, weights, nearest flag ----------------
  localparam int OM_W = LEN_W + CHAN_W;

  logic [OM_W-1:0]  ofs_full;
  logic [OFS_W-1:0] ofs_nxt;
  logic [WGT_W-1:0] wl_nxt;
  logic [WGT_W-1:0] wr_nxt;
  logic [FRAC_W-1:0] inv_frac;

  assign ofs_full = OM_W'(s2_pos_r) * OM_W'(chan_r);
  assign ofs_nxt  = (ofs_full > OM_W'(16'hFFFF)) ? {OFS_W{1'b1}} : OFS_W'(ofs_full);
  assign inv_frac = FRAC_ONE - s2_frac_r;

  rtpw_weight #(.COEF_BITS(COEF_BITS)) u_wgt_left (
    .w_q16  (inv_frac),
    .weight (wl_nxt)
  );

  rtpw_weight #(.COEF_BITS(COEF_BITS)) u_wgt_right (
    .w_q16  (s2_frac_r),
    .weight (wr_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      out_source_offset <= ofs_nxt;
      out_weight_left   <= wl_nxt;
      out_weight_right  <= wr_nxt;
      out_pick_left     <= (s2_frac_r <= HALF_Q16);
    end
  end

  // ---------------- checks ----------------
  `RTPW_ASSERT_NXT(a_pipe_adv, clk, rst_n, s2_vld_r, out_valid, "stage 2 request lost")
  `RTPW_ASSERT_IMP(a_pick_dom, clk, rst_n, out_valid && out_pick_left, out_weight_left >= out_weight_right, "nearest flag disagrees with weights")
  `RTPW_ASSERT_IMP(a_wgt_max, clk, rst_n, out_valid, (32'(out_weight_left) <= WMAX) && (32'(out_weight_right) <= WMAX), "weight above full scale")
  `RTPW_ASSERT_IMP(a_edge_frac, clk, rst_n, s2_vld_r, (s2_frac_r <= FRAC_ONE) && (s2_pos_r < border_m1), "clamped position out of range")

endmodule

// File: rtl/rtpw_weight.sv
// Rounds a Q16 weight to COEF_BITS, saturating at the 12-bit output range.
module rtpw_weight #(
  parameter int COEF_BITS = rtpw_pkg::COEF_BITS_DEF
) (
  input  logic [rtpw_pkg::FRAC_W-1:0] w_q16,
  output logic [rtpw_pkg::WGT_W-1:0]  weight
);
  import rtpw_pkg::*;

  localparam int SW = FRAC_W + COEF_BITS + 1;
  localparam int RW = SW - 16;

  logic [SW-1:0] sum_w;
  logic [RW-1:0] rnd;

  // round half up: (w * 2^COEF_BITS + 2^15) >> 16
  assign sum_w = (SW'(w_q16) << COEF_BITS) + SW'(HALF_Q16);
  assign rnd   = sum_w[SW-1:16];

  always_comb begin
    if (32'(rnd) > 32'd4095) begin
      weight = {WGT_W{1'b1}};
    end else begin
      weight = WGT_W'(rnd);
    end
  end

endmodule

// File: tb/resize_tap_checker.sv
// Checker for the resize tap/weight generator: watches requests, registers and results.
module resize_tap_checker #(
  parameter int COEF_BITS = rtpw_pkg::COEF_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [rtpw_pkg::IDX_W-1:0]   in_dest_index,
  input  logic                         out_valid,
  input  logic [rtpw_pkg::OFS_W-1:0]   out_source_offset,
  input  logic [rtpw_pkg::WGT_W-1:0]   out_weight_left,
  input  logic [rtpw_pkg::WGT_W-1:0]   out_weight_right,
  input  logic                         out_pick_left,
  input  logic                         cfg_we,
  input  logic [rtpw_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [rtpw_pkg::SCALE_W-1:0] cfg_wdata,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  import rtpw_pkg::*;

  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    logic [WGT_W-1:0] wl;
    logic [WGT_W-1:0] wr;
    logic             pick;
  } tap_t;

  logic [SCALE_W-1:0] scale_q816;
  logic [LEN_W-1:0]   src_len;
  logic [CHAN_W-1:0]  chan_cnt;
  tap_t               taps_due[$];

  function automatic logic [WGT_W-1:0] round_weight(longint w_q16);
    longint v;
    v = ((w_q16 << COEF_BITS) + 32768) >>> 16;
    if (v > 4095) v = 4095;
    return v[WGT_W-1:0];
  endfunction

  function automatic tap_t tap_for_index(logic [IDX_W-1:0] idx);
    longint pos_q17, pos, frac, border, ofs;
    tap_t t;
    pos_q17 = (2 * longint'(idx) + 1) * longint'(scale_q816) - 65536;
    border  = (src_len < 2) ? 2 : longint'(src_len);
    if (pos_q17 < 0) begin
      pos  = 0;
      frac = 0;
    end else begin
      pos  = pos_q17 >>> 17;
      frac = (pos_q17 & 'h1FFFF) >>> 1;
    end
    // right border: clamp to last pair, all weight on the right tap
    if (pos >= border - 1) begin
      pos  = border - 2;
      frac = 65536;
    end
    ofs = pos * longint'(chan_cnt);
    if (ofs > 65535) ofs = 65535;
    t.ofs  = ofs[OFS_W-1:0];
    t.wl   = round_weight(65536 - frac);
    t.wr   = round_weight(frac);
    t.pick = (frac <= 32768);
    return t;
  endfunction

  always @(posedge clk) begin
    tap_t want, got;
    if (!rst_n) begin
      scale_q816 = SCALE_RST;
      src_len    = LEN_RST;
      chan_cnt   = CHAN_RST;
      taps_due.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid) begin
        got = '{out_source_offset, out_weight_left, out_weight_right, out_pick_left};
        if (taps_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = taps_due.pop_front();
          checked++;
          if (got.ofs !== want.ofs) begin
            $display("%0t: source_offset expected %0d actual %0d", $time, want.ofs, got.ofs);
            errors++;
          end
          if (got.wl !== want.wl) begin
            $display("%0t: weight_left expected %0d actual %0d", $time, want.wl, got.wl);
            errors++;
          end
          if (got.wr !== want.wr) begin
            $display("%0t: weight_right expected %0d actual %0d", $time, want.wr, got.wr);
            errors++;
          end
          if (got.pick !== want.pick) begin
            $display("%0t: pick_left expected %0b actual %0b", $time, want.pick, got.pick);
            errors++;
          end
        end
      end
      // requests see the registers as they stood before this edge
      if (start && !busy) taps_due.push_back(tap_for_index(in_dest_index));
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE: scale_q816 = cfg_wdata;
          REG_LEN:   src_len    = cfg_wdata[LEN_W-1:0];
          REG_CHAN:  chan_cnt   = cfg_wdata[CHAN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = taps_due.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the resize tap/weight generator: stimulus, register phases, verdict.
module tb_top;
  import rtpw_pkg::*;

  // Generous ceiling: ~450 requests with idle gaps, a few dozen drains.
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 6;    // slack after the pipeline has emptied
  localparam int RAND_PHASES = 10;
  localparam int PHASE_REQS  = 43;

  // register index the block does not decode
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [IDX_W-1:0]   in_dest_index;
  logic               out_valid;
  logic [OFS_W-1:0]   out_source_offset;
  logic [WGT_W-1:0]   out_weight_left;
  logic [WGT_W-1:0]   out_weight_right;
  logic               out_pick_left;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [SCALE_W-1:0] cfg_wdata;

  int errors, pending, checked;
  int cycles;
  int n_requests, n_settings;
  bit idle_on;

  resize_tap_position_weight_gen_top dut (
    .clk, .rst_n, .start, .busy, .in_dest_index,
    .out_valid, .out_source_offset, .out_weight_left, .out_weight_right, .out_pick_left,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  resize_tap_checker chk (
    .clk, .rst_n, .start, .busy, .in_dest_index,
    .out_valid, .out_source_offset, .out_weight_left, .out_weight_right, .out_pick_left,
    .cfg_we, .cfg_index, .cfg_wdata,
    .errors, .pending, .checked
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One request: optional idle gap, then hold start until accepted.
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    if (idle_on && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start         <= 1'b1;
    in_dest_index <= idx;
    do @(posedge clk); while (busy);
    n_requests++;
  endtask

  // Stop sending and wait until every expected result is back, plus pipeline slack.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; caller makes sure the block is idle.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_axis(input logic [SCALE_W-1:0] scale, input logic [SCALE_W-1:0] len,
                          input logic [SCALE_W-1:0] chans);
    drain_pipe();
    write_reg(REG_SCALE, scale);
    write_reg(REG_LEN, len);
    write_reg(REG_CHAN, chans);
    n_settings++;
  endtask

  initial begin
    int dest_len, len, mode;
    longint scale;
    logic [IDX_W-1:0] idx;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_dest_index = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SCALE;
    cfg_wdata     = '0;
    idle_on       = 1'b1;
    n_settings    = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // Reset values (scale 1.0, two samples): left edge, right border clamp, top index.
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'hFFF);
    // Scale 1.5 over a long axis, 16 channels: ordinary interpolation.
    set_axis(24'h018000, 24'd4096, 24'd16);
    send_index(12'd0);
    send_index(12'd1);
    send_index(12'd2);
    send_index(12'd1000);
    // Scale 2.0 puts every fraction exactly at one half: tie goes left.
    drain_pipe();
    write_reg(REG_SCALE, 24'h020000);
    send_index(12'd0);
    send_index(12'd7);
    // Scale 0.5: index 0 lands left of sample 0 and clamps.
    drain_pipe();
    write_reg(REG_SCALE, 24'h008000);
    send_index(12'd0);
    send_index(12'd3);
    // Zero scale is always a negative position; unknown index must not touch scale.
    drain_pipe();
    write_reg(REG_SCALE, 24'd0);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    send_index(12'd0);
    send_index(12'hFFF);
    // Largest scale with widest length/channels: border clamp and offset saturation.
    set_axis(24'hFFFFFF, 24'd8191, 24'd31);
    send_index(12'd0);
    send_index(12'hFFF);
    // Minimum scale, zero channels: offset forced to zero.
    set_axis(24'd1, 24'd4096, 24'd0);
    send_index(12'd0);
    send_index(12'hFFF);
    // Short source lengths behave as two samples.
    set_axis(24'h010000, 24'd0, 24'd1);
    send_index(12'd0);
    send_index(12'd1);
    drain_pipe();
    write_reg(REG_LEN, 24'd1);
    send_index(12'd0);
    send_index(12'd5);

    // --- random part ---
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = $urandom_range(0, 9);
      // one long stretch without any idle gaps
      idle_on = (ph != 3);
      if (mode < 7) begin
        // realistic scaler: scale ~ src/dst so indexes sweep the source
        len      = $urandom_range(2, 4096);
        dest_len = $urandom_range(1, 4096);
        scale    = ((longint'(len) << 16) + dest_len / 2) / dest_len;
        if (scale < 1) scale = 1;
        if (scale > 24'hFFFFFF) scale = 24'hFFFFFF;
        if ($urandom_range(0, 3) == 0) begin
          drain_pipe();
          write_reg(REG_UNUSED, SCALE_W'($urandom()));
        end
        set_axis(scale[SCALE_W-1:0], SCALE_W'(len), SCALE_W'($urandom_range(1, 16)));
      end else begin
        // anything the ports allow, junk in the high data bits included
        dest_len = 4096;
        set_axis(SCALE_W'($urandom()), SCALE_W'($urandom()), SCALE_W'($urandom()));
      end
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (ph == 5 && k == PHASE_REQS / 2) drain_pipe();
        if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom());
        else idx = IDX_W'($urandom_range(0, dest_len - 1));
        send_index(idx);
      end
    end

    drain_pipe();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests over %0d register settings, %0d results compared.",
             n_requests, n_settings, checked);
    $display("Directed edges, border clamps, saturation and random axes all exercised.");
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Errors: %0d, results still owed: %0d", errors, pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rtpw_pkg.sv
rtl/rtpw_weight.sv
rtl/resize_tap_position_weight_gen_top.sv
tb/resize_tap_checker.sv
tb/tb_top.sv
